// ===== design/dpf_pkg.sv =====
// shared types, constants and helper functions for the dsss ppdu framer
package dpf_pkg;

    localparam int MAX_PSDU_BYTES = 4095;
    localparam int LEN_W          = 12;
    localparam int USEC_W         = 16;
    localparam int DIV_X_W        = 17;
    localparam int RECIP_W        = 18;
    localparam int RECIP_SHIFT    = 21;
    // ceil(2^21 / 11), exact quotient for every dividend below 2^17
    localparam logic [RECIP_W-1:0] RECIP_11 = 18'd190651;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int STEP_W         = 5;
    localparam int LONG_SYNC_LEN  = 18;
    localparam int SHORT_SYNC_LEN = 9;
    localparam int HDR_LEN        = 6;

    localparam logic [7:0] SEED_LONG     = 8'h1B;
    localparam logic [7:0] SEED_SHORT    = 8'h6C;
    localparam logic [7:0] SERVICE_BASE  = 8'h04;
    localparam logic [7:0] SERVICE_EXT   = 8'h84;
    localparam logic [15:0] CRC_PRESET   = 16'hFFFF;
    localparam logic [15:0] CRC_TAPS     = 16'h0810;

    // rate modes
    localparam logic [2:0] MODE_LONG_LAST = 3'd3;
    localparam logic [2:0] MODE_MAX       = 3'd6;
    localparam logic [2:0] MODE_SHORT_OFS = 3'd3;

    // speed codes
    localparam logic [1:0] SPEED_1M  = 2'd0;
    localparam logic [1:0] SPEED_2M  = 2'd1;
    localparam logic [1:0] SPEED_5M5 = 2'd2;
    localparam logic [1:0] SPEED_11M = 2'd3;

    // header byte positions
    localparam logic [2:0] HB_SIGNAL  = 3'd0;
    localparam logic [2:0] HB_SERVICE = 3'd1;
    localparam logic [2:0] HB_LEN_LO  = 3'd2;
    localparam logic [2:0] HB_LEN_HI  = 3'd3;
    localparam logic [2:0] HB_CRC_LO  = 3'd4;
    localparam logic [2:0] HB_CRC_HI  = 3'd5;

    // register address map
    localparam int PADDR_W = 3;
    localparam logic [0:0] REG_RATE_MODE = 1'b0;

    localparam logic [7:0] LONG_SYNC [LONG_SYNC_LEN] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hA0, 8'hF3
    };
    localparam logic [7:0] SHORT_SYNC [SHORT_SYNC_LEN] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hCF, 8'h05
    };
    localparam logic [7:0] SIGNAL_CODE [4] = '{8'h0A, 8'h14, 8'h37, 8'h6E};

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             first_byte;
        logic             last_byte;
        logic [LEN_W-1:0] psdu_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
        logic       end_of_packet;
    } out_item_t;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              first_byte;
        logic              last_byte;
        logic [2:0]        mode;
        logic              long_pre;
        logic [1:0]        speed;
        logic [USEC_W-1:0] usec;
        logic [3:0]        x_lo;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    typedef struct packed {
        logic in_prefix;
    } back_status_t;

    typedef enum logic [0:0] {
        BK_NEXT,
        BK_PREFIX
    } back_state_t;

    // self-synchronizing scrambler over one byte, lsb first; returns {state, out}
    function automatic logic [15:0] scramble_byte(input logic [7:0] state,
                                                  input logic [7:0] din);
        logic [7:0] s;
        logic [7:0] o;
        logic       b;
        s = state;
        o = '0;
        for (int j = 0; j < 8; j++) begin
            b    = din[j] ^ s[3] ^ s[6];
            o[j] = b;
            s    = {s[6:0], b};
        end
        return {s, o};
    endfunction

    // crc-16 update over one header byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] din);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int j = 0; j < 8; j++) begin
            fb = c[15] ^ din[j];
            if (fb) begin
                c = c ^ CRC_TAPS;
            end
            c = {c[14:0], fb};
        end
        return c;
    endfunction

endpackage

// ===== design/dpf_front.sv =====
// front end: accepts requests, drops strays, works out rate and length fields
module dpf_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dpf_pkg::in_item_t  s_item,
    input  logic [2:0]         rate_mode,
    input  dpf_pkg::q_status_t q_stat,
    output logic               push,
    output dpf_pkg::q_entry_t  entry
);
    import dpf_pkg::*;

    logic                     in_packet_reg;
    logic                     in_packet_next;
    logic                     accept;
    logic [2:0]               mode;
    logic                     long_pre;
    logic [1:0]               speed;
    logic [LEN_W-1:0]         len;
    logic [DIV_X_W-1:0]       div_x;
    logic [DIV_X_W+RECIP_W-1:0] prod;
    logic [USEC_W-1:0]        usec;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        mode     = (rate_mode > MODE_MAX) ? 3'd0 : rate_mode;
        long_pre = (mode <= MODE_LONG_LAST);
        speed    = long_pre ? mode[1:0] : 2'(mode - MODE_SHORT_OFS);

        if ({1'b0, s_item.psdu_length} > (LEN_W+1)'(MAX_PSDU_BYTES)) begin
            len = LEN_W'(MAX_PSDU_BYTES);
        end else begin
            len = s_item.psdu_length;
        end

        // 5.5M divides 16*L+10 by 11, 11M divides 8*L+10 by 11
        if (speed == SPEED_5M5) begin
            div_x = {1'b0, len, 4'b0000} + DIV_X_W'(10);
        end else begin
            div_x = {2'b00, len, 3'b000} + DIV_X_W'(10);
        end
        prod = (DIV_X_W+RECIP_W)'(div_x) * (DIV_X_W+RECIP_W)'(RECIP_11);

        case (speed)
            SPEED_1M: usec = {1'b0, len, 3'b000};
            SPEED_2M: usec = {2'b00, len, 2'b00};
            default:  usec = USEC_W'(prod[DIV_X_W+RECIP_W-1:RECIP_SHIFT]);
        endcase

        entry.data_byte  = s_item.data_byte;
        entry.first_byte = s_item.first_byte;
        entry.last_byte  = s_item.last_byte;
        entry.mode       = mode;
        entry.long_pre   = long_pre;
        entry.speed      = speed;
        entry.usec       = usec;
        entry.x_lo       = div_x[3:0];

        push           = accept && (s_item.first_byte || in_packet_reg);
        in_packet_next = in_packet_reg;
        if (push) begin
            in_packet_next = !s_item.last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg <= 1'b0;
        end else begin
            in_packet_reg <= in_packet_next;
        end
    end

endmodule

// ===== design/dpf_queue.sv =====
// short request queue between front end and back end
module dpf_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  dpf_pkg::q_entry_t  entry,
    input  logic               pop,
    output dpf_pkg::q_entry_t  head,
    output dpf_pkg::q_status_t q_stat
);
    import dpf_pkg::*;

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.valid = (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/dpf_back.sv =====
// back end: emits tag, preamble, header and scrambled data into the output register
module dpf_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dpf_pkg::q_entry_t    head,
    input  dpf_pkg::q_status_t   q_stat,
    output logic                 pop,
    output dpf_pkg::back_status_t b_stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dpf_pkg::out_item_t   m_item
);
    import dpf_pkg::*;

    back_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [7:0]        scr_reg, scr_next;
    logic [15:0]       crc_reg, crc_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic              adv;
    logic [STEP_W-1:0] pre_len;
    logic [STEP_W-1:0] last_step;
    logic [STEP_W-1:0] sidx;
    logic [STEP_W-1:0] hidx;
    logic [7:0]        service;
    logic [7:0]        signal;
    logic [7:0]        m11;
    logic [3:0]        rem;
    logic [31:0]       hdr;
    logic [15:0]       crc_fin;
    logic [7:0]        raw_byte;
    logic [15:0]       scr_res;

    assign m_valid          = out_valid_reg;
    assign m_item           = out_item_reg;
    assign b_stat.in_prefix = (state_reg == BK_PREFIX);
    assign adv              = !out_valid_reg || m_ready;

    always_comb begin
        // remainder of the 11M division, only its low bits matter
        m11     = 8'(head.usec[3:0]) * 8'd11;
        rem     = head.x_lo - m11[3:0];
        service = ((head.speed == SPEED_11M) && (rem <= 4'd2)) ? SERVICE_EXT
                                                                : SERVICE_BASE;
        signal  = SIGNAL_CODE[head.speed];
        hdr     = {head.usec, service, signal};
        crc_fin = crc_reg ^ CRC_PRESET;

        pre_len   = head.long_pre ? STEP_W'(LONG_SYNC_LEN) : STEP_W'(SHORT_SYNC_LEN);
        last_step = pre_len + STEP_W'(HDR_LEN + 1);
        sidx      = step_reg - 1'b1;
        hidx      = step_reg - pre_len - 1'b1;

        raw_byte = head.data_byte;
        if (state_reg == BK_PREFIX) begin
            if (step_reg <= pre_len) begin
                raw_byte = head.long_pre ? LONG_SYNC[sidx] : SHORT_SYNC[sidx[3:0]];
            end else if (step_reg != last_step) begin
                case (hidx[2:0])
                    HB_SIGNAL:  raw_byte = hdr[7:0];
                    HB_SERVICE: raw_byte = hdr[15:8];
                    HB_LEN_LO:  raw_byte = hdr[23:16];
                    HB_LEN_HI:  raw_byte = hdr[31:24];
                    HB_CRC_LO:  raw_byte = crc_fin[7:0];
                    HB_CRC_HI:  raw_byte = crc_fin[15:8];
                    default:    raw_byte = 8'h00;
                endcase
            end
        end
        scr_res = scramble_byte(scr_reg, raw_byte);

        state_next     = state_reg;
        step_next      = step_reg;
        scr_next       = scr_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        pop            = 1'b0;

        if (adv) begin
            out_valid_next = 1'b0;
            if (q_stat.valid) begin
                out_valid_next = 1'b1;
                case (state_reg)
                    BK_NEXT: begin
                        if (head.first_byte) begin
                            // rate tag goes out unscrambled, scrambler reseeds
                            out_item_next.out_byte      = {5'b00000, head.mode};
                            out_item_next.end_of_run    = 1'b0;
                            out_item_next.end_of_packet = 1'b0;
                            scr_next   = head.long_pre ? SEED_LONG : SEED_SHORT;
                            crc_next   = CRC_PRESET;
                            step_next  = STEP_W'(1);
                            state_next = BK_PREFIX;
                        end else begin
                            out_item_next.out_byte      = scr_res[7:0];
                            out_item_next.end_of_run    = 1'b1;
                            out_item_next.end_of_packet = head.last_byte;
                            scr_next = scr_res[15:8];
                            pop      = 1'b1;
                        end
                    end
                    BK_PREFIX: begin
                        out_item_next.out_byte = scr_res[7:0];
                        scr_next = scr_res[15:8];
                        // crc runs over the four header bytes during the preamble
                        if (step_reg <= STEP_W'(4)) begin
                            case (sidx[1:0])
                                2'd0:    crc_next = crc_byte(crc_reg, hdr[7:0]);
                                2'd1:    crc_next = crc_byte(crc_reg, hdr[15:8]);
                                2'd2:    crc_next = crc_byte(crc_reg, hdr[23:16]);
                                default: crc_next = crc_byte(crc_reg, hdr[31:24]);
                            endcase
                        end
                        if (step_reg == last_step) begin
                            out_item_next.end_of_run    = 1'b1;
                            out_item_next.end_of_packet = head.last_byte;
                            pop        = 1'b1;
                            step_next  = '0;
                            state_next = BK_NEXT;
                        end else begin
                            out_item_next.end_of_run    = 1'b0;
                            out_item_next.end_of_packet = 1'b0;
                            step_next = step_reg + 1'b1;
                        end
                    end
                    default: begin
                        state_next = BK_NEXT;
                        step_next  = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_NEXT;
            step_reg      <= '0;
            scr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            scr_reg       <= scr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg      <= crc_next;
        out_item_reg <= out_item_next;
    end

endmodule

// ===== design/dsss_ppdu_framer.sv =====
// top level of the dsss ppdu framer: register port, front end, queue, back end
// a data request reaches m_valid through the queue and the back-end output register
// throughput while m_ready is high: data requests one per cycle; a first request
//   yields 26 results (long preamble) or 17 (short), one per cycle, set by the back-end sequencer
// the two-entry queue lets input run on while the prefix drains, then stalls it
// reset: synchronous active-low aresetn clears rate_mode, queue, sequencer state
module dsss_ppdu_framer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dpf_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // request input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dpf_pkg::in_item_t             s_item,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output dpf_pkg::out_item_t            m_item
);
    import dpf_pkg::*;

    logic [2:0]   rate_mode_reg, rate_mode_next;
    logic         cfg_write;
    logic         push;
    logic         pop;
    q_entry_t     entry;
    q_entry_t     head;
    q_status_t    q_stat;
    back_status_t b_stat;

    // register port: always ready, word address selects the register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2:2] == REG_RATE_MODE);

    always_comb begin
        rate_mode_next = rate_mode_reg;
        if (cfg_write) begin
            rate_mode_next = pwdata[2:0];
        end
        if (paddr[2:2] == REG_RATE_MODE) begin
            prdata = {29'd0, rate_mode_reg};
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_mode_reg <= '0;
        end else begin
            rate_mode_reg <= rate_mode_next;
        end
    end

    // front end classifies each request and precomputes the length field
    dpf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .rate_mode (rate_mode_reg),
        .q_stat    (q_stat),
        .push      (push),
        .entry     (entry)
    );

    // decoupling queue
    dpf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .entry   (entry),
        .pop     (pop),
        .head    (head),
        .q_stat  (q_stat)
    );

    // back end holds a first request at the queue head until its data byte goes out
    dpf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_stat  (q_stat),
        .pop     (pop),
        .b_stat  (b_stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

`ifndef NO_ASSERTIONS
    // while the prefix runs, its first request must sit at the queue head
    a_prefix_head: assert property (@(posedge aclk) disable iff (!aresetn)
        b_stat.in_prefix |-> (q_stat.valid && head.first_byte))
        else $error("prefix running without a first request at queue head");

    // a pending result that does not end its run comes only from a live prefix
    a_run_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.end_of_run) |-> b_stat.in_prefix)
        else $error("open run result outside the prefix sequence");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending right after reset");
`endif

endmodule

// ===== tb/dsss_ppdu_framer_tb.sv =====
// self-checking testbench for the dsss ppdu framer: predictor, driver, monitor, register port
`timescale 1ns / 1ps

module dsss_ppdu_framer_tb;
    import dpf_pkg::*;

    // extra cycles after the last expected byte before touching the register port
    localparam int TAIL_CYCLES = 8;
    // register 0 sits at byte address 0
    localparam logic [PADDR_W-1:0] RATE_MODE_ADDR = {REG_RATE_MODE, 2'b00};

    // preamble and sfd bytes, before scrambling
    localparam int         LONG_SYNC_CNT   = 16;
    localparam logic [7:0] LONG_SYNC_BYTE  = 8'hFF;
    localparam logic [7:0] LONG_SFD_LO     = 8'hA0;
    localparam logic [7:0] LONG_SFD_HI     = 8'hF3;
    localparam int         SHORT_SYNC_CNT  = 7;
    localparam logic [7:0] SHORT_SYNC_BYTE = 8'h00;
    localparam logic [7:0] SHORT_SFD_LO    = 8'hCF;
    localparam logic [7:0] SHORT_SFD_HI    = 8'h05;
    // signal field per speed code
    localparam logic [7:0] SIG_BYTE [4] = '{8'h0A, 8'h14, 8'h37, 8'h6E};

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // register port
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    // request and result channels
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    dsss_ppdu_framer u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // predictor state: our own copy of the scrambler, packet flag and rate register
    logic [7:0] scr_state = '0;
    logic       open_pkt  = 1'b0;
    logic [2:0] rate_cfg  = '0;

    out_item_t ppdu_bytes_q[$];   // expected output bytes, oldest first
    in_item_t  pend_q[$];         // requests not yet driven

    int  err_cnt   = 0;
    int  acc_cnt   = 0;           // requests accepted (posedge side)
    int  drv_cnt   = 0;           // requests put on the bus (negedge side)
    int  src_gap   = 0;
    int  snk_stall = 0;
    logic src_idle = 1'b1;        // per-phase enables for random idling
    logic snk_idle = 1'b1;

    // stimulus-side tracking, so ignored requests are known when queued
    logic gen_open  = 1'b0;
    int   counted_n = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want_v);
        $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want_v);
        err_cnt++;
    endtask

    // one byte through the self-synchronizing scrambler, lsb first
    function automatic logic [7:0] scramble_next(input logic [7:0] din);
        logic [7:0] o;
        logic       b;
        o = '0;
        for (int j = 0; j < 8; j++) begin
            b         = din[j] ^ scr_state[3] ^ scr_state[6];
            o[j]      = b;
            scr_state = {scr_state[6:0], b};
        end
        return o;
    endfunction

    // inverted crc-16 over the 32 header bits, lsb first
    function automatic logic [15:0] hdr_crc16(input logic [31:0] hdr);
        logic [15:0] c;
        logic        fb;
        c = CRC_PRESET;
        for (int i = 0; i < 32; i++) begin
            fb = c[15] ^ hdr[i];
            if (fb) begin
                c = c ^ CRC_TAPS;
            end
            c = {c[14:0], fb};
        end
        return ~c;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic eor, input logic eop);
        out_item_t r;
        r.out_byte      = b;
        r.end_of_run    = eor;
        r.end_of_packet = eop;
        ppdu_bytes_q.push_back(r);
    endtask

    // expected output for one accepted request
    task automatic frame_request(input in_item_t req);
        logic [2:0]  mode;
        logic [2:0]  m_ofs;
        logic        long_pre;
        logic [1:0]  speed;
        logic [31:0] nbits;
        logic [31:0] usec;
        logic [7:0]  service;
        logic [31:0] hdr;
        logic [15:0] crc;
        if (req.first_byte) begin
            // the undefined mode 7 behaves as mode 0, tag included
            mode     = (rate_cfg > MODE_MAX) ? 3'd0 : rate_cfg;
            long_pre = (mode <= MODE_LONG_LAST);
            m_ofs    = mode - MODE_SHORT_OFS;
            speed    = long_pre ? mode[1:0] : m_ofs[1:0];
            nbits    = {20'b0, req.psdu_length} * 32'd8;
            service  = SERVICE_BASE;
            case (speed)
                SPEED_1M:  usec = nbits;
                SPEED_2M:  usec = {20'b0, req.psdu_length} * 32'd4;
                SPEED_5M5: usec = (nbits * 32'd2 + 32'd10) / 32'd11;
                default: begin
                    usec = (nbits + 32'd10) / 32'd11;
                    // length extension when the rounding overshoots by a byte or more
                    if (usec * 32'd11 - nbits >= 32'd8) begin
                        service = SERVICE_EXT;
                    end
                end
            endcase
            hdr = {usec[15:8], usec[7:0], service, SIG_BYTE[speed]};
            crc = hdr_crc16(hdr);

            // tag goes out in the clear
            push_byte({5'b0, mode}, 1'b0, 1'b0);
            scr_state = long_pre ? SEED_LONG : SEED_SHORT;
            if (long_pre) begin
                for (int i = 0; i < LONG_SYNC_CNT; i++) begin
                    push_byte(scramble_next(LONG_SYNC_BYTE), 1'b0, 1'b0);
                end
                push_byte(scramble_next(LONG_SFD_LO), 1'b0, 1'b0);
                push_byte(scramble_next(LONG_SFD_HI), 1'b0, 1'b0);
            end else begin
                for (int i = 0; i < SHORT_SYNC_CNT; i++) begin
                    push_byte(scramble_next(SHORT_SYNC_BYTE), 1'b0, 1'b0);
                end
                push_byte(scramble_next(SHORT_SFD_LO), 1'b0, 1'b0);
                push_byte(scramble_next(SHORT_SFD_HI), 1'b0, 1'b0);
            end
            for (int i = 0; i < 4; i++) begin
                push_byte(scramble_next(hdr[8*i +: 8]), 1'b0, 1'b0);
            end
            push_byte(scramble_next(crc[7:0]), 1'b0, 1'b0);
            push_byte(scramble_next(crc[15:8]), 1'b0, 1'b0);
            open_pkt = 1'b1;
        end else if (!open_pkt) begin
            // stray byte outside a packet: dropped, state untouched
            return;
        end
        push_byte(scramble_next(req.data_byte), 1'b1, req.last_byte);
        if (req.last_byte) begin
            open_pkt = 1'b0;
        end
    endtask

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap(input logic en);
        int r;
        r = $urandom_range(0, 99);
        if (!en || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    // request driver: changes inputs on the falling edge, holds a request until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || acc_cnt == drv_cnt) begin
            if (src_gap > 0) begin
                s_valid <= 1'b0;
                src_gap--;
            end else if (pend_q.size() != 0) begin
                s_item  <= pend_q.pop_front();
                s_valid <= 1'b1;
                drv_cnt++;
                src_gap = pick_gap(src_idle);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result sink: random back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (snk_stall > 0) begin
            m_ready <= 1'b0;
            snk_stall--;
        end else begin
            m_ready <= 1'b1;
            snk_stall = pick_gap(snk_idle);
        end
    end

    // monitor: predict on every accepted request, check every accepted result
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                frame_request(s_item);
                acc_cnt++;
            end
            if (m_valid && m_ready) begin
                if (ppdu_bytes_q.size() == 0) begin
                    report_mismatch("unexpected output byte", 32'(m_item.out_byte), 0);
                end else begin
                    want = ppdu_bytes_q.pop_front();
                    if (m_item.out_byte !== want.out_byte) begin
                        report_mismatch("out_byte", 32'(m_item.out_byte),
                                        32'(want.out_byte));
                    end
                    if (m_item.end_of_run !== want.end_of_run) begin
                        report_mismatch("end_of_run", 32'(m_item.end_of_run),
                                        32'(want.end_of_run));
                    end
                    if (m_item.end_of_packet !== want.end_of_packet) begin
                        report_mismatch("end_of_packet", 32'(m_item.end_of_packet),
                                        32'(want.end_of_packet));
                    end
                end
            end
        end
    end

    // queue one request; only those the block acts on are counted
    task automatic push_req(input logic [7:0] data, input logic first, input logic last,
                            input logic [LEN_W-1:0] len);
        in_item_t r;
        r.data_byte   = data;
        r.first_byte  = first;
        r.last_byte   = last;
        r.psdu_length = len;
        pend_q.push_back(r);
        if (first || gen_open) begin
            counted_n++;
            gen_open = !last;
        end
    endtask

    // wait until every request is taken and every byte has come out, then settle
    task automatic wait_idle();
        do @(negedge aclk);
        while (pend_q.size() != 0 || acc_cnt != drv_cnt || ppdu_bytes_q.size() != 0);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    // apb write of rate_mode, then read it back
    task automatic set_rate_mode(input logic [2:0] mode);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RATE_MODE_ADDR;
        pwdata  <= {29'b0, mode};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rate_cfg = mode;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {29'b0, mode}) begin
            report_mismatch("rate_mode readback", prdata, {29'b0, mode});
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random traffic: mostly well-formed packets, some stray and broken ones
    task automatic run_traffic(input int target);
        int stop_at;
        int r;
        int nb;
        stop_at = counted_n + target;
        while (counted_n < stop_at) begin
            r  = $urandom_range(0, 99);
            nb = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 5) : $urandom_range(6, 24);
            if (r < 82) begin
                // well-formed packet; length field honest half the time
                push_req(8'($urandom_range(0, 255)), 1'b1, nb == 1,
                         $urandom_range(0, 1) ? LEN_W'(nb) : LEN_W'($urandom));
                for (int i = 1; i < nb; i++) begin
                    push_req(8'($urandom_range(0, 255)), 1'b0, i == nb - 1,
                             LEN_W'($urandom));
                end
            end else if (r < 90) begin
                // stray byte: continues an open packet or gets dropped
                push_req(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                         LEN_W'($urandom));
            end else begin
                // broken packet: no last byte, the next first byte abandons it
                push_req(8'($urandom_range(0, 255)), 1'b1, 1'b0, LEN_W'($urandom));
                for (int i = 1; i < nb; i++) begin
                    push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, LEN_W'($urandom));
                end
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: long preamble at 1 Mb/s
        set_rate_mode(3'd0);
        push_req(8'h00, 1'b1, 1'b1, 12'd0);      // zero length
        push_req(8'hFF, 1'b1, 1'b1, 12'd4095);   // longest length
        push_req(8'h5A, 1'b0, 1'b0, 12'hFFF);    // byte outside a packet
        push_req(8'h3C, 1'b1, 1'b0, 12'd3);
        push_req(8'h81, 1'b0, 1'b0, 12'd0);
        push_req(8'h7E, 1'b0, 1'b1, 12'hAAA);
        push_req(8'h11, 1'b1, 1'b0, 12'd2);      // opens a packet that the next first byte abandons
        push_req(8'h22, 1'b1, 1'b1, 12'd5);
        push_req(8'h33, 1'b0, 1'b1, 12'h555);    // last byte outside a packet
        wait_idle();
        set_rate_mode(3'd1);
        push_req(8'hA5, 1'b1, 1'b1, 12'd1);
        wait_idle();
        set_rate_mode(3'd2);
        push_req(8'h96, 1'b1, 1'b1, 12'd11);
        push_req(8'h69, 1'b1, 1'b1, 12'd4095);
        wait_idle();
        // 11 Mb/s: length 1 without, length 3 with the length extension
        set_rate_mode(3'd3);
        push_req(8'h01, 1'b1, 1'b1, 12'd1);
        push_req(8'h02, 1'b1, 1'b1, 12'd3);
        wait_idle();
        set_rate_mode(3'd4);
        push_req(8'h10, 1'b1, 1'b1, 12'd100);
        wait_idle();
        set_rate_mode(3'd5);
        push_req(8'h20, 1'b1, 1'b1, 12'd4095);
        wait_idle();
        set_rate_mode(3'd6);
        push_req(8'h40, 1'b1, 1'b1, 12'd3);
        push_req(8'h80, 1'b1, 1'b1, 12'd4095);
        wait_idle();
        // undefined mode falls back to mode 0 with a zero tag
        set_rate_mode(3'd7);
        push_req(8'hC3, 1'b1, 1'b1, 12'd7);
        wait_idle();

        // random phases over the extremes and a few random modes
        for (int ph = 0; ph < 8; ph++) begin
            src_idle = (ph != 2);
            snk_idle = (ph != 2) && (ph != 5);
            case (ph)
                0:       set_rate_mode(3'd6);
                1:       set_rate_mode(3'd0);
                2:       set_rate_mode(3'd7);
                default: set_rate_mode(3'($urandom_range(0, 7)));
            endcase
            run_traffic(45);
        end

        if (ppdu_bytes_q.size() != 0) begin
            report_mismatch("bytes never produced", ppdu_bytes_q.size(), 0);
        end
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #15_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dpf_pkg.sv
design/dpf_front.sv
design/dpf_queue.sv
design/dpf_back.sv
design/dsss_ppdu_framer.sv
tb/dsss_ppdu_framer_tb.sv
